// ===== rtl/epoch_seconds_to_calendar_date_defines.svh =====
// Assertion macros for the epoch seconds to calendar date block.
// Needs clk and rst_n in scope at the point of use.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

// same-cycle implication, off during reset
`define ECD_ASSERT_IMPL(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("ecd: assertion failed");

// next-cycle implication, off during reset
`define ECD_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("ecd: assertion failed");

`endif

// ===== rtl/ecd_pkg.sv =====
// Constants for the epoch seconds to calendar date pipeline.
// No dependencies.
package ecd_pkg;

  // seconds per day is 2^7 * 675; quotient by 675 via reciprocal
  localparam logic [9:0]  DAY_DIV     = 10'd675;
  localparam logic [15:0] DAY_RECIP   = 16'd49710;   // floor(2^25 / 675)
  localparam logic [19:0] DAY_SHIFT   = 20'd719469;  // day 1 is 0000-03-01

  // century term: cent - cent/4 is 15, or 16 from this day number on
  localparam logic [19:0] CENT_STEP_DAY = 20'd767010;
  localparam logic [19:0] CENT_BASE     = 20'd15;

  localparam logic [9:0]  SCALE       = 10'd1000;
  localparam logic [7:0]  BIAS_YEAR   = 8'd200;
  localparam logic [18:0] YEAR_SCALED = 19'd365250;
  localparam logic [11:0] YEAR_RECIP  = 12'd2939;    // floor(2^30 / 365250)
  localparam logic [8:0]  YEAR_DAYS   = 9'd365;

  localparam logic [11:0] HOUR_SECS   = 12'd3600;
  localparam logic [5:0]  HOUR_RECIP  = 6'd36;       // floor(2^17 / 3600)
  localparam logic [5:0]  MIN_SECS    = 6'd60;
  localparam logic [6:0]  MIN_RECIP   = 7'd68;       // floor(2^12 / 60)

  // months counted from March: last day-of-year before each month
  localparam logic [8:0] MONTH_BASE [12] = '{
    9'd0,   9'd31,  9'd61,  9'd92,  9'd122, 9'd153,
    9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
  };
  localparam logic [3:0] MONTH_WRAP = 4'd10;         // January in March-based count

endpackage

// ===== rtl/epoch_seconds_to_calendar_date.sv =====
// Epoch seconds to Gregorian date and time of day, nine-stage pipeline.
// Depends on ecd_pkg and epoch_seconds_to_calendar_date_defines.svh.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+----------------------------
//  input   | in_epoch_seconds                   | start high, busy low
//  result  | out_year .. out_second             | out_strobe, one cycle
//
// One item per cycle. The stages are set by the reciprocal multiplies for days,
// years, hours and minutes, each followed by its correction step.
// busy is always low and the result side cannot stall.
// Synchronous reset clears the stage valid bits only.
`include "epoch_seconds_to_calendar_date_defines.svh"

module epoch_seconds_to_calendar_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_strobe,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);
  import ecd_pkg::*;

  localparam int NSTG = 9;

  logic            in_acc;
  logic [NSTG-1:0] vld_r, vld_nxt;

  // stage 1: days reciprocal product
  logic [31:0] s1_x_r;
  logic [40:0] s1_prod_r, s1_prod_nxt;
  // stage 2: day quotient estimate and remainder
  logic [15:0] s2_q_r, s2_q_nxt;
  logic [10:0] s2_rm_r, s2_rm_nxt;
  logic [6:0]  s2_lo_r;
  logic [25:0] s2_t, s2_diff;
  // stage 3: day number and time of day
  logic [19:0] s3_n_r, s3_n_nxt;
  logic [16:0] s3_tod_r, s3_tod_nxt;
  logic        s3_fix;
  logic [9:0]  s3_rem;
  // stage 4: scaled day number, hour estimate product
  logic [29:0] s4_a_r, s4_a_nxt;
  logic [19:0] s4_n1_r, s4_n1_nxt;
  logic [22:0] s4_hp_r, s4_hp_nxt;
  logic [16:0] s4_tod_r;
  // stage 5: year reciprocal product, hour remainder
  logic [41:0] s5_yp_r, s5_yp_nxt;
  logic [29:0] s5_a_r;
  logic [19:0] s5_n1_r;
  logic [4:0]  s5_h_r;
  logic [12:0] s5_rh_r, s5_rh_nxt;
  logic [5:0]  s5_h0;
  logic [16:0] s5_hsub;
  // stage 6: year estimate and remainder, hour fixed, minute product
  logic [11:0] s6_y_r, s6_y_nxt;
  logic [19:0] s6_ry_r, s6_ry_nxt;
  logic [19:0] s6_n1_r;
  logic [4:0]  s6_hr_r, s6_hr_nxt;
  logic [11:0] s6_rem_r, s6_rem_nxt;
  logic [18:0] s6_mp_r, s6_mp_nxt;
  logic [29:0] s6_ydiff;
  logic        s6_hfix;
  // stage 7: year fixed, minute estimate
  logic [11:0] s7_yr_r, s7_yr_nxt;
  logic [19:0] s7_n1_r;
  logic [4:0]  s7_hr_r;
  logic [5:0]  s7_mi_r, s7_mi_nxt;
  logic [6:0]  s7_rm_r, s7_rm_nxt;
  logic [11:0] s7_mdiff;
  // stage 8: day of year, minute and second fixed
  logic [8:0]  s8_doy_r, s8_doy_nxt;
  logic [11:0] s8_yr_r;
  logic [4:0]  s8_hr_r;
  logic [5:0]  s8_mi_r, s8_mi_nxt;
  logic [5:0]  s8_se_r, s8_se_nxt;
  logic [19:0] s8_dfull;
  logic        s8_mfix;
  // stage 9: month, day, year wrap
  logic [3:0]  s9_mo;
  logic [11:0] out_year_nxt;
  logic [3:0]  out_month_nxt;
  logic [4:0]  out_day_nxt;

  // no back-pressure anywhere in the pipe
  assign busy   = 1'b0;
  assign in_acc = start & ~busy;

  assign vld_nxt = {vld_r[NSTG-2:0], in_acc};

  // stage 1: seconds / 128 times reciprocal of 675
  always_comb begin
    s1_prod_nxt = 41'(in_epoch_seconds[31:7]) * 41'(DAY_RECIP);
  end

  // stage 2: estimate is exact or one low; form remainder
  always_comb begin
    s2_q_nxt  = s1_prod_r[40:25];
    s2_t      = 26'(s2_q_nxt) * 26'(DAY_DIV);
    s2_diff   = {1'b0, s1_x_r[31:7]} - s2_t;
    s2_rm_nxt = s2_diff[10:0];
  end

  // stage 3: correct day quotient, rebuild seconds of day
  always_comb begin
    s3_fix     = (s2_rm_r >= 11'(DAY_DIV));
    s3_rem     = s3_fix ? 10'(s2_rm_r - 11'(DAY_DIV)) : s2_rm_r[9:0];
    s3_tod_nxt = {s3_rem, s2_lo_r};
    s3_n_nxt   = 20'(s2_q_r + 16'(s3_fix)) + DAY_SHIFT;
  end

  // stage 4: century correction, scale for year divide, hour product
  always_comb begin
    s4_n1_nxt = s3_n_r + CENT_BASE + 20'(s3_n_r >= CENT_STEP_DAY);
    s4_a_nxt  = 30'(s4_n1_nxt) * 30'(SCALE) - 30'(BIAS_YEAR);
    s4_hp_nxt = 23'(s3_tod_r) * 23'(HOUR_RECIP);
  end

  // stage 5: year reciprocal product, hour remainder
  always_comb begin
    s5_yp_nxt = 42'(s4_a_r) * 42'(YEAR_RECIP);
    s5_h0     = s4_hp_r[22:17];
    s5_hsub   = s4_tod_r - 17'(s5_h0) * 17'(HOUR_SECS);
    s5_rh_nxt = s5_hsub[12:0];
  end

  // stage 6: year remainder; hour correction and minute product
  always_comb begin
    s6_y_nxt   = s5_yp_r[41:30];
    s6_ydiff   = s5_a_r - 30'(s6_y_nxt) * 30'(YEAR_SCALED);
    s6_ry_nxt  = s6_ydiff[19:0];
    s6_hfix    = (s5_rh_r >= 13'(HOUR_SECS));
    s6_hr_nxt  = s5_h_r + 5'(s6_hfix);
    s6_rem_nxt = s6_hfix ? 12'(s5_rh_r - 13'(HOUR_SECS)) : s5_rh_r[11:0];
    s6_mp_nxt  = 19'(s6_rem_nxt) * 19'(MIN_RECIP);
  end

  // stage 7: year correction; minute estimate and remainder
  always_comb begin
    s7_yr_nxt = s6_y_r + 12'(s6_ry_r >= 20'(YEAR_SCALED));
    s7_mi_nxt = s6_mp_r[17:12];
    s7_mdiff  = s6_rem_r - 12'(s7_mi_nxt) * 12'(MIN_SECS);
    s7_rm_nxt = s7_mdiff[6:0];
  end

  // stage 8: day of year = n1 - floor(365.25 * yr); minute correction
  always_comb begin
    s8_dfull   = s7_n1_r - 20'(s7_yr_r) * 20'(YEAR_DAYS) - 20'(s7_yr_r[11:2]);
    s8_doy_nxt = s8_dfull[8:0];
    s8_mfix    = (s7_rm_r >= 7'(MIN_SECS));
    s8_mi_nxt  = s7_mi_r + 6'(s8_mfix);
    s8_se_nxt  = s8_mfix ? 6'(s7_rm_r - 7'(MIN_SECS)) : s7_rm_r[5:0];
  end

  // stage 9: month from March, day of month, shift to January start
  always_comb begin
    s9_mo = '0;
    for (int k = 1; k < 12; k++) begin
      if (s8_doy_r > MONTH_BASE[k]) s9_mo = 4'(k);
    end
    out_day_nxt = 5'(s8_doy_r - MONTH_BASE[s9_mo]);
    if (s9_mo >= MONTH_WRAP) begin
      out_month_nxt = s9_mo - 4'd9;
      out_year_nxt  = s8_yr_r + 12'd1;
    end else begin
      out_month_nxt = s9_mo + 4'd3;
      out_year_nxt  = s8_yr_r;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    s1_x_r    <= in_epoch_seconds;
    s1_prod_r <= s1_prod_nxt;

    s2_q_r  <= s2_q_nxt;
    s2_rm_r <= s2_rm_nxt;
    s2_lo_r <= s1_x_r[6:0];

    s3_n_r   <= s3_n_nxt;
    s3_tod_r <= s3_tod_nxt;

    s4_a_r   <= s4_a_nxt;
    s4_n1_r  <= s4_n1_nxt;
    s4_hp_r  <= s4_hp_nxt;
    s4_tod_r <= s3_tod_r;

    s5_yp_r <= s5_yp_nxt;
    s5_a_r  <= s4_a_r;
    s5_n1_r <= s4_n1_r;
    s5_h_r  <= s5_h0[4:0];
    s5_rh_r <= s5_rh_nxt;

    s6_y_r   <= s6_y_nxt;
    s6_ry_r  <= s6_ry_nxt;
    s6_n1_r  <= s5_n1_r;
    s6_hr_r  <= s6_hr_nxt;
    s6_rem_r <= s6_rem_nxt;
    s6_mp_r  <= s6_mp_nxt;

    s7_yr_r <= s7_yr_nxt;
    s7_n1_r <= s6_n1_r;
    s7_hr_r <= s6_hr_r;
    s7_mi_r <= s7_mi_nxt;
    s7_rm_r <= s7_rm_nxt;

    s8_doy_r <= s8_doy_nxt;
    s8_yr_r  <= s7_yr_r;
    s8_hr_r  <= s7_hr_r;
    s8_mi_r  <= s8_mi_nxt;
    s8_se_r  <= s8_se_nxt;

    out_year   <= out_year_nxt;
    out_month  <= out_month_nxt;
    out_day    <= out_day_nxt;
    out_hour   <= s8_hr_r;
    out_minute <= s8_mi_r;
    out_second <= s8_se_r;
  end

  assign out_strobe = vld_r[NSTG-1];

  // checks on the corrected day remainder, final field ranges and acceptance into stage 1
  `ECD_ASSERT_IMPL(a_tod_range, vld_r[2], s3_tod_r < 17'd86400)
  `ECD_ASSERT_IMPL(a_time_range, out_strobe,
                   (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
  `ECD_ASSERT_IMPL(a_date_range, out_strobe,
                   (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day != 5'd0) &&
                   (out_year >= 12'd1970) && (out_year <= 12'd2106))
  `ECD_ASSERT_NEXT(a_in_flight, in_acc, vld_r[0])

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for epoch_seconds_to_calendar_date: random-gap driver, strobe monitor,
// and a 64-bit integer model of the civil-date breakdown.
// Depends only on the RTL of epoch_seconds_to_calendar_date.
module testbench;

  // civil calendar constants (days from 0000-03-01, scaled by 1000)
  localparam longint unsigned DAY_SECS    = 86400;
  localparam longint unsigned HOUR_SECS   = 3600;
  localparam longint unsigned MIN_SECS    = 60;
  localparam longint unsigned EPOCH_DAY   = 719469;
  localparam longint unsigned K_SCALE     = 1000;
  localparam longint unsigned K_CENTURY   = 36524250;
  localparam longint unsigned K_YEAR      = 365250;
  localparam longint unsigned K_MONTH     = 30600;
  localparam longint unsigned Y_BIAS      = 200;
  localparam longint unsigned M_BIAS      = 500;
  localparam int unsigned     RAND_ITEMS  = 1880;
  localparam int unsigned     MAX_REPORTS = 10;
  localparam int unsigned     TAIL_CYCLES = 20;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_date_t;

  typedef struct {
    logic [31:0] secs;
    bit          wait_idle;  // hold off until all results are back
  } stamp_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_epoch_seconds = '0;
  logic        busy;
  logic        out_strobe;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;

  stamp_item_t stamp_q[$];
  cal_date_t   pending_dates[$];
  int unsigned n_issued = 0;
  int unsigned n_results = 0;
  int unsigned err_count = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  epoch_seconds_to_calendar_date uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_strobe       (out_strobe),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // seconds since 1970 -> Gregorian date and time of day
  function automatic cal_date_t civil_from_epoch(input logic [31:0] secs);
    longint unsigned s, tod, dn, cent, n1, yr, doy, mo, dd;
    cal_date_t r;
    s    = 64'(secs);
    tod  = s % DAY_SECS;
    dn   = s / DAY_SECS + EPOCH_DAY;
    cent = (dn * K_SCALE - Y_BIAS) / K_CENTURY;
    n1   = dn + cent - cent / 4;
    yr   = (n1 * K_SCALE - Y_BIAS) / K_YEAR;
    doy  = n1 - (K_YEAR * yr) / K_SCALE;
    mo   = (doy * K_SCALE - M_BIAS) / K_MONTH;
    dd   = (doy * K_SCALE - K_MONTH * mo + M_BIAS) / K_SCALE;
    // March-based month count; Jan/Feb belong to the next year
    if (mo <= 9) begin
      r.month = 4'(mo + 3);
      r.year  = 12'(yr);
    end else begin
      r.month = 4'(mo - 9);
      r.year  = 12'(yr + 1);
    end
    r.day    = 5'(dd);
    r.hour   = 5'(tod / HOUR_SECS);
    r.minute = 6'((tod % HOUR_SECS) / MIN_SECS);
    r.second = 6'((tod % HOUR_SECS) % MIN_SECS);
    return r;
  endfunction

  // mostly back to back, some short gaps, rare long ones, bursts with none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 2) burst_left = $urandom_range(80, 30);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(15, 4);
    return $urandom_range(60, 20);
  endfunction

  task automatic add_stamp(input logic [31:0] secs, input bit wait_idle);
    stamp_item_t it;
    it.secs      = secs;
    it.wait_idle = wait_idle;
    stamp_q.push_back(it);
  endtask

  // random timestamp: uniform, day edges, range ends, 2100 leap rule, small
  function automatic logic [31:0] pick_stamp();
    int unsigned     roll;
    longint unsigned d, t;
    roll = $urandom_range(99);
    if (roll < 40) return $urandom;
    if (roll < 70) begin
      d = $urandom_range(49709);
      case ($urandom_range(3))
        0:       t = 0;
        1:       t = 1;
        2:       t = DAY_SECS - 1;
        default: t = $urandom_range(86399);
      endcase
      return 32'(d * DAY_SECS + t);
    end
    if (roll < 80) return $urandom_range(32'hFFFF_FFFF, 32'hFFF0_0000);
    if (roll < 90) return $urandom_range(32'd4107_542_400 + 32'd300_000,
                                         32'd4107_542_400 - 32'd300_000);
    return $urandom_range(200_000);
  endfunction

  task automatic report_field(input string fname, input int unsigned want,
                              input int unsigned got);
    if (want !== got) begin
      if (err_count < MAX_REPORTS)
        $display("mismatch %s (result %0d): expected %0d, got %0d", fname, n_results,
                 want, got);
      err_count++;
    end
  endtask

  // driver: presents queued items, holds each until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) n_issued++;
      if (!(start && busy)) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (stamp_q.size() != 0 &&
                     !(stamp_q[0].wait_idle && n_results < n_issued)) begin
          in_epoch_seconds <= stamp_q[0].secs;
          start            <= 1'b1;
          void'(stamp_q.pop_front());
          gap_left = pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: records accepted items, checks each strobed result
  always @(posedge clk) begin
    cal_date_t want;
    if (rst_n) begin
      if (start && !busy) pending_dates.push_back(civil_from_epoch(in_epoch_seconds));
      if (out_strobe) begin
        n_results <= n_results + 1;
        if (pending_dates.size() == 0) begin
          if (err_count < MAX_REPORTS)
            $display("result with no item pending: %0d-%0d-%0d %0d:%0d:%0d", out_year,
                     out_month, out_day, out_hour, out_minute, out_second);
          err_count++;
        end else begin
          want = pending_dates.pop_front();
          report_field("year",   want.year,   out_year);
          report_field("month",  want.month,  out_month);
          report_field("day",    want.day,    out_day);
          report_field("hour",   want.hour,   out_hour);
          report_field("minute", want.minute, out_minute);
          report_field("second", want.second, out_second);
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    // range ends, bit patterns, day and year edges
    add_stamp(32'd0, 1'b0);
    add_stamp(32'hFFFF_FFFF, 1'b0);
    add_stamp(32'hFFFF_FFFE, 1'b0);
    add_stamp(32'hAAAA_AAAA, 1'b0);
    add_stamp(32'h5555_5555, 1'b0);
    add_stamp(32'd86399, 1'b0);
    add_stamp(32'd86400, 1'b0);
    add_stamp(32'd31535999, 1'b0);
    add_stamp(32'd31536000, 1'b0);
    add_stamp(32'h7FFF_FFFF, 1'b0);
    add_stamp(32'h8000_0000, 1'b1);
    // leap days: 1972 and 2000 are leap, 2100 is not
    add_stamp(32'd68169600, 1'b0);
    add_stamp(32'd68169599, 1'b0);
    add_stamp(32'd951782400, 1'b0);
    add_stamp(32'd951868799, 1'b0);
    add_stamp(32'd951868800, 1'b0);
    add_stamp(32'd4102444800, 1'b0);
    add_stamp(32'd4102444799, 1'b0);
    add_stamp(32'd4107542399, 1'b0);
    add_stamp(32'd4107542400, 1'b0);
    add_stamp(32'd4107628800, 1'b0);
    for (int unsigned i = 0; i < RAND_ITEMS; i++)
      add_stamp(pick_stamp(), (i == 500 || i == 1300));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (stamp_q.size() != 0 || start || pending_dates.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (err_count == 0 && pending_dates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
